@@ hw/rtl/md5_pkg.sv @@
// shared types, constants and round tables of the md5 engine
package md5_pkg;

    // op codes carried on the input tuser
    localparam logic [1:0] OP_ABSORB  = 2'd0;
    localparam logic [1:0] OP_FINAL   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // how message words are formed from the block buffer
    localparam logic [1:0] MODE_DATA    = 2'd0; // raw buffer bytes
    localparam logic [1:0] MODE_PAD     = 2'd1; // pending bytes, pad mark, zeros
    localparam logic [1:0] MODE_PAD_LEN = 2'd2; // as above plus bit count at the tail
    localparam logic [1:0] MODE_LEN     = 2'd3; // zeros plus bit count at the tail

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_BYTE = 6'h3f;
    localparam logic [5:0] LAST_ROUND = 6'd63;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // controller to datapath
    typedef struct packed {
        logic       absorb;    // write byte, bump fill and bit count
        logic       restart;   // reload initial chain, clear counts
        logic       fin_load;  // copy chain into working chain
        logic       abcd_load; // load round registers from target
        logic       round_en;  // run one round
        logic       fold;      // add round registers into target
        logic       tgt_work;  // target is working chain, else chain
        logic [1:0] mode;      // message word forming
        logic [5:0] rnd;       // current round
        logic [3:0] rd_addr;   // buffer word to fetch
        logic [1:0] out_sel;   // digest word on the output
    } md5_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_last; // next absorbed byte completes the block
        logic fill_late; // padding spills into a second block
    } md5_stat_t;

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] rr;
        logic [3:0] idx;
        rr = rnd[3:0];
        unique case (rnd[5:4])
            2'd0: idx = rr;
            2'd1: idx = 4'(rr * 4'd5 + 4'd1);
            2'd2: idx = 4'(rr * 4'd3 + 4'd5);
            2'd3: idx = 4'(rr * 4'd7);
        endcase
        return idx;
    endfunction

    // left rotate amount of a round
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] s;
        unique case ({rnd[5:4], rnd[1:0]})
            4'd0:  s = 5'd7;
            4'd1:  s = 5'd12;
            4'd2:  s = 5'd17;
            4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;
            4'd5:  s = 5'd9;
            4'd6:  s = 5'd14;
            4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;
            4'd9:  s = 5'd11;
            4'd10: s = 5'd16;
            4'd11: s = 5'd23;
            4'd12: s = 5'd6;
            4'd13: s = 5'd10;
            4'd14: s = 5'd15;
            4'd15: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

@@ hw/rtl/md5_hash_engine.sv @@
// md5 hash engine top level: byte stream in, digest words out
//
// channel   dir  tdata               tuser             tlast
// s_*       in   data_byte [7:0]     op [1:0]          -
// m_*       out  digest_word [31:0]  word_index [1:0]  last_word
//
// an absorbed byte needs no round pass; the byte that fills a 64-byte block
// holds the input for a load, 64 rounds on one shared round unit and an
// add back. a finalize runs one such pass, or two when 56 or more bytes are
// pending, then four output items, one per cycle while m_tready is high.
// restart and unused op codes give no item.
// rst_n clears control, counts and the chain at once; no clearing pass.
// a stalled output holds the digest word and keeps the input closed
module md5_hash_engine
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic [1:0]  s_tuser,  // [1:0] op
    // digest stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // [31:0] digest_word
    output logic [1:0]  m_tuser,  // [1:0] word_index
    output logic        m_tlast   // last_word
);

    md5_cmd_t  cmd;
    md5_stat_t stat;

    // sequencing: one round per cycle, output item count
    md5_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tlast    (m_tlast),
        .word_index (m_tuser),
        .cmd        (cmd),
        .stat       (stat)
    );

    // buffer, padding, round logic and chaining words
    md5_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (s_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .digest_word (m_tdata)
    );

endmodule

@@ hw/rtl/md5_datapath.sv @@
// md5 datapath: block buffer, chaining words, round registers and counters
module md5_datapath
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  md5_cmd_t    cmd,
    output md5_stat_t   stat,
    output logic [31:0] digest_word
);

    logic [3:0][7:0] buf_mem [16];
    logic [3:0][7:0] rd_word_reg;
    logic [3:0]      rd_idx_reg;

    logic [31:0] chain_reg [4];
    logic [31:0] work_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [63:0] bit_count_reg;
    logic [5:0]  fill_reg;

    logic [31:0] msg_word;
    logic [31:0] f_val;
    logic [31:0] sum_val;
    logic [63:0] rot_val;
    logic [31:0] b_next;

    function automatic logic [7:0] form_byte(
        input logic [1:0]  mode,
        input logic [5:0]  idx,
        input logic [7:0]  raw,
        input logic [5:0]  fill,
        input logic [63:0] count
    );
        logic [7:0] len_b;
        logic [7:0] pad_b;
        logic [7:0] res;
        len_b = count[{idx[2:0], 3'b000} +: 8];
        if (idx < fill)
            pad_b = raw;
        else if (idx == fill)
            pad_b = PAD_MARK;
        else
            pad_b = 8'h00;
        unique case (mode)
            MODE_DATA:    res = raw;
            MODE_PAD:     res = pad_b;
            MODE_PAD_LEN: res = (idx >= LEN_POS) ? len_b : pad_b;
            MODE_LEN:     res = (idx >= LEN_POS) ? len_b : 8'h00;
        endcase
        return res;
    endfunction

    // block buffer, one byte lane written per absorbed item
    always_ff @(posedge clk)
    begin
        if (cmd.absorb)
            buf_mem[fill_reg[5:2]][fill_reg[1:0]] <= data_byte;
        rd_word_reg <= buf_mem[cmd.rd_addr];
        rd_idx_reg  <= cmd.rd_addr;
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            msg_word[8*k +: 8] = form_byte(cmd.mode, {rd_idx_reg, 2'(k)},
                                           rd_word_reg[k], fill_reg, bit_count_reg);
        end
    end

    always_comb
    begin
        unique case (cmd.rnd[5:4])
            2'd0: f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2: f_val = b_reg ^ c_reg ^ d_reg;
            2'd3: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        sum_val = a_reg + f_val + msg_word + ROUND_K[cmd.rnd];
        rot_val = {sum_val, sum_val} << rot_amount(cmd.rnd);
        b_next  = b_reg + rot_val[63:32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.abcd_load)
        begin
            a_reg <= cmd.tgt_work ? work_reg[0] : chain_reg[0];
            b_reg <= cmd.tgt_work ? work_reg[1] : chain_reg[1];
            c_reg <= cmd.tgt_work ? work_reg[2] : chain_reg[2];
            d_reg <= cmd.tgt_work ? work_reg[3] : chain_reg[3];
        end
        else if (cmd.round_en)
        begin
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_next;
        end
    end

    // working chain of the last finalize
    always_ff @(posedge clk)
    begin
        if (cmd.fin_load)
            work_reg <= chain_reg;
        else if (cmd.fold && cmd.tgt_work)
        begin
            work_reg[0] <= work_reg[0] + a_reg;
            work_reg[1] <= work_reg[1] + b_reg;
            work_reg[2] <= work_reg[2] + c_reg;
            work_reg[3] <= work_reg[3] + d_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
            bit_count_reg <= '0;
            fill_reg      <= '0;
        end
        else if (cmd.restart)
        begin
            chain_reg     <= '{INIT_A, INIT_B, INIT_C, INIT_D};
            bit_count_reg <= '0;
            fill_reg      <= '0;
        end
        else
        begin
            if (cmd.absorb)
            begin
                bit_count_reg <= bit_count_reg + 64'd8;
                fill_reg      <= fill_reg + 6'd1;
            end
            if (cmd.fold && !cmd.tgt_work)
            begin
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
        end
    end

    assign stat.fill_last = (fill_reg == LAST_BYTE);
    assign stat.fill_late = (fill_reg >= LEN_POS);
    assign digest_word    = work_reg[cmd.out_sel];

endmodule

@@ hw/rtl/md5_ctrl.sv @@
// md5 controller: item decode, round sequencing and digest output
module md5_ctrl
    import md5_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [1:0] op,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic       m_tlast,
    output logic [1:0] word_index,
    output md5_cmd_t   cmd,
    input  md5_stat_t  stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PRIME = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [1:0] mode_reg, mode_next;
    logic       tgt_reg, tgt_next;
    logic       second_reg, second_next;
    logic [1:0] idx_reg, idx_next;
    logic       accept;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == ST_EMIT);
    assign m_tlast    = (idx_reg == 2'd3);
    assign word_index = idx_reg;

    always_comb
    begin
        state_next  = state_reg;
        rnd_next    = rnd_reg;
        mode_next   = mode_reg;
        tgt_next    = tgt_reg;
        second_next = second_reg;
        idx_next    = idx_reg;

        cmd           = '0;
        cmd.rnd       = rnd_reg;
        cmd.mode      = mode_reg;
        cmd.tgt_work  = tgt_reg;
        cmd.out_sel   = idx_reg;
        cmd.rd_addr   = msg_index(6'd0);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_ABSORB:
                        begin
                            cmd.absorb = 1'b1;
                            if (stat.fill_last)
                            begin
                                mode_next   = MODE_DATA;
                                tgt_next    = 1'b0;
                                second_next = 1'b0;
                                state_next  = ST_PRIME;
                            end
                        end
                        OP_FINAL:
                        begin
                            cmd.fin_load = 1'b1;
                            mode_next    = stat.fill_late ? MODE_PAD : MODE_PAD_LEN;
                            tgt_next     = 1'b1;
                            second_next  = stat.fill_late;
                            state_next   = ST_PRIME;
                        end
                        OP_RESTART:
                        begin
                            cmd.restart = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PRIME:
            begin
                cmd.abcd_load = 1'b1;
                rnd_next      = 6'd0;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.round_en = 1'b1;
                cmd.rd_addr  = msg_index(6'(rnd_reg + 6'd1));
                rnd_next     = 6'(rnd_reg + 6'd1);
                if (rnd_reg == LAST_ROUND)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                cmd.fold = 1'b1;
                if (second_reg)
                begin
                    second_next = 1'b0;
                    mode_next   = MODE_LEN;
                    state_next  = ST_PRIME;
                end
                else if (tgt_reg)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    idx_next = idx_reg + 2'd1;
                    if (idx_reg == 2'd3)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rnd_reg    <= '0;
            mode_reg   <= MODE_DATA;
            tgt_reg    <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rnd_reg    <= rnd_next;
            mode_reg   <= mode_next;
            tgt_reg    <= tgt_next;
            second_reg <= second_next;
            idx_reg    <= idx_next;
        end
    end

endmodule
